// File: hdl/cftr_pkg.sv
// Types, identifiers and payload layouts shared by the CAN frame throttled repacker.
package cftr_pkg;

	localparam int NumSlots = 5;

	typedef logic [2:0]  slot_t;
	typedef logic [1:0]  part_t;
	typedef logic [15:0] interval_t;
	typedef logic [31:0] tick_t;
	typedef logic [28:0] can_id_t;

	localparam slot_t SLOT_ERPM_VOLTAGE = 3'd0;
	localparam slot_t SLOT_TEMPS        = 3'd1;
	localparam slot_t SLOT_FAN_PUMP     = 3'd2;
	localparam slot_t SLOT_DRIVE_ENABLE = 3'd3;
	localparam slot_t SLOT_VCU_ERROR    = 3'd4;

	localparam can_id_t ID_ERPM_VOLTAGE = 29'h241E;
	localparam can_id_t ID_TEMPS        = 29'h221E;
	localparam can_id_t ID_FAN_PUMP     = 29'h30A;
	localparam can_id_t ID_DRIVE_ENABLE = 29'h31A;
	localparam can_id_t ID_VCU_ERROR    = 29'h25;

	localparam interval_t INTERVAL_RESET [NumSlots] = '{
		16'd100, 16'd100, 16'd2000, 16'd100, 16'd100
	};

	localparam logic [7:0] PID_ERPM      = 8'h01;
	localparam logic [7:0] PID_VOLTAGE   = 8'h02;
	localparam logic [7:0] PID_TEMP_A    = 8'h22;
	localparam logic [7:0] PID_TEMP_B    = 8'h04;
	localparam logic [7:0] PID_TEMP_C    = 8'h03;
	localparam logic [7:0] PID_FAN       = 8'h11;
	localparam logic [7:0] PID_PUMP      = 8'h06;
	localparam logic [7:0] PID_DRIVE_VCU = 8'h05;

	localparam part_t PART_FIRST  = 2'd0;
	localparam part_t PART_SECOND = 2'd1;

	// Frame bytes that appear in some payload; byte 4 is never forwarded.
	typedef struct packed {
		logic [7:0] b0;
		logic [7:0] b1;
		logic [7:0] b2;
		logic [7:0] b3;
		logic [7:0] b5;
		logic [7:0] b6;
		logic [7:0] b7;
	} frame_bytes_t;

	typedef struct packed {
		logic [7:0] id;
		logic [2:0] length;
		logic [7:0] byte0;
		logic [7:0] byte1;
		logic [7:0] byte2;
		logic [7:0] byte3;
		logic       last;
	} telemetry_t;

	function automatic telemetry_t make_payload(slot_t slot, part_t part, frame_bytes_t fb);
		telemetry_t p;
		begin
			p = '0;
			case (slot)
				SLOT_ERPM_VOLTAGE: begin
					if (part == PART_FIRST) begin
						p.id = PID_ERPM; p.length = 3'd4;
						p.byte0 = fb.b0; p.byte1 = fb.b1; p.byte2 = fb.b2; p.byte3 = fb.b3;
					end else begin
						p.id = PID_VOLTAGE; p.length = 3'd2;
						p.byte0 = fb.b6; p.byte1 = fb.b7; p.last = 1'b1;
					end
				end
				SLOT_TEMPS: begin
					if (part == PART_FIRST) begin
						p.id = PID_TEMP_A; p.length = 3'd1; p.byte0 = fb.b0;
					end else if (part == PART_SECOND) begin
						p.id = PID_TEMP_B; p.length = 3'd2;
						p.byte0 = fb.b2; p.byte1 = fb.b3;
					end else begin
						p.id = PID_TEMP_C; p.length = 3'd2;
						p.byte0 = fb.b0; p.byte1 = fb.b1; p.last = 1'b1;
					end
				end
				SLOT_FAN_PUMP: begin
					if (part == PART_FIRST) begin
						p.id = PID_FAN; p.length = 3'd1; p.byte0 = fb.b0;
					end else begin
						p.id = PID_PUMP; p.length = 3'd1; p.byte0 = fb.b5; p.last = 1'b1;
					end
				end
				default: begin
					p.id = PID_DRIVE_VCU; p.length = 3'd1; p.byte0 = fb.b3; p.last = 1'b1;
				end
			endcase
			return p;
		end
	endfunction

endpackage

// File: hdl/can_frame_throttled_repacker_core.sv
// Top level of the CAN frame throttled repacker: throttle check, frame stage and payload output.
//
// Each request is one received CAN frame. The identifier is decoded and the throttle check
// (elapsed time against the configured interval) is made in the cycle the frame is taken, and
// the frame's last-sent time is updated in that same cycle, so frames may arrive back to back.
// A forwarded frame waits in a one-frame stage and leaves as one to three payload requests,
// one per cycle while the output is not stalled; the frame is registered in the frame stage
// and each payload in the output register before it appears. A frame that is dropped never
// enters the frame stage. The frame stage is the limit on rate: it holds a forwarded frame
// until its last payload is loaded, and the next frame can be taken in that same cycle.
module can_frame_throttled_repacker_core (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// frame_identifier[28:0], frame_byte0..frame_byte7[92:29], now_ms[124:93], zero[127:125]
	input  logic [127:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// payload_id[7:0], payload_length[10:8], payload_byte0..payload_byte3[42:11], zero[47:43]
	output logic [47:0]  m_tdata,
	output logic         m_tlast,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [15:0]  cfg_data
);

	cftr_pkg::can_id_t      in_ident;
	cftr_pkg::tick_t        in_now;
	cftr_pkg::frame_bytes_t in_bytes;
	cftr_pkg::slot_t        in_slot;
	logic                   in_hit;
	cftr_pkg::tick_t        elapsed;
	logic                   in_pass;
	logic                   accept;

	cftr_pkg::interval_t    interval_q [cftr_pkg::NumSlots];
	cftr_pkg::tick_t        last_sent_q [cftr_pkg::NumSlots];

	logic                   frame_valid_s1;
	cftr_pkg::slot_t        slot_s1;
	cftr_pkg::part_t        part_s1;
	cftr_pkg::frame_bytes_t bytes_s1;

	cftr_pkg::telemetry_t   cur_payload;
	logic                   out_load;
	logic                   frame_done;

	logic                   out_valid_q;
	cftr_pkg::telemetry_t   payload_q;

	assign in_ident    = s_tdata[28:0];
	assign in_bytes.b0 = s_tdata[36:29];
	assign in_bytes.b1 = s_tdata[44:37];
	assign in_bytes.b2 = s_tdata[52:45];
	assign in_bytes.b3 = s_tdata[60:53];
	assign in_bytes.b5 = s_tdata[76:69];
	assign in_bytes.b6 = s_tdata[84:77];
	assign in_bytes.b7 = s_tdata[92:85];
	assign in_now      = s_tdata[124:93];

	always_comb begin
		in_hit  = 1'b1;
		in_slot = cftr_pkg::SLOT_ERPM_VOLTAGE;
		case (in_ident)
			cftr_pkg::ID_ERPM_VOLTAGE: in_slot = cftr_pkg::SLOT_ERPM_VOLTAGE;
			cftr_pkg::ID_TEMPS:        in_slot = cftr_pkg::SLOT_TEMPS;
			cftr_pkg::ID_FAN_PUMP:     in_slot = cftr_pkg::SLOT_FAN_PUMP;
			cftr_pkg::ID_DRIVE_ENABLE: in_slot = cftr_pkg::SLOT_DRIVE_ENABLE;
			cftr_pkg::ID_VCU_ERROR:    in_slot = cftr_pkg::SLOT_VCU_ERROR;
			default:                   in_hit  = 1'b0;
		endcase
	end

	assign elapsed = in_now - last_sent_q[in_slot];
	assign in_pass = in_hit && (elapsed > {16'd0, interval_q[in_slot]});

	assign cur_payload = cftr_pkg::make_payload(slot_s1, part_s1, bytes_s1);
	assign out_load    = frame_valid_s1 && (!out_valid_q || m_tready);
	assign frame_done  = out_load && cur_payload.last;
	assign s_tready    = !frame_valid_s1 || frame_done;
	assign accept      = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < cftr_pkg::NumSlots; i++) begin
				interval_q[i]  <= cftr_pkg::INTERVAL_RESET[i];
				last_sent_q[i] <= '0;
			end
		end else begin
			if (cfg_we && (cfg_index < 3'(cftr_pkg::NumSlots))) begin
				interval_q[cfg_index] <= cfg_data;
			end
			if (accept && in_pass) begin
				last_sent_q[in_slot] <= in_now;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_valid_s1 <= 1'b0;
			part_s1        <= cftr_pkg::PART_FIRST;
		end else begin
			if (accept && in_pass) begin
				frame_valid_s1 <= 1'b1;
				part_s1        <= cftr_pkg::PART_FIRST;
			end else if (frame_done) begin
				frame_valid_s1 <= 1'b0;
			end else if (out_load) begin
				part_s1 <= part_s1 + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && in_pass) begin
			slot_s1  <= in_slot;
			bytes_s1 <= in_bytes;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			payload_q <= cur_payload;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tlast  = payload_q.last;
	assign m_tdata  = {5'd0, payload_q.byte3, payload_q.byte2, payload_q.byte1,
		payload_q.byte0, payload_q.length, payload_q.id};

endmodule

// File: tb/sv/testbench.sv
// Self-checking testbench for the CAN frame throttled repacker core.
module testbench;

	localparam logic [2:0] REG_ERPM_VOLTAGE  = 3'd0;
	localparam logic [2:0] REG_TEMPS         = 3'd1;
	localparam logic [2:0] REG_FAN_PUMP      = 3'd2;
	localparam logic [2:0] REG_DRIVE_ENABLE  = 3'd3;
	localparam logic [2:0] REG_VCU_ERROR     = 3'd4;
	localparam logic [2:0] REG_FIRST_UNUSED  = 3'd5;
	localparam logic [2:0] REG_LAST_UNUSED   = 3'd7;

	localparam cftr_pkg::can_id_t KNOWN_IDS [cftr_pkg::NumSlots] = '{
		cftr_pkg::ID_ERPM_VOLTAGE, cftr_pkg::ID_TEMPS, cftr_pkg::ID_FAN_PUMP,
		cftr_pkg::ID_DRIVE_ENABLE, cftr_pkg::ID_VCU_ERROR
	};

	localparam int RANDOM_PHASES = 6;
	localparam int FRAMES_PER_PHASE = 60;

	logic         clk = 1'b0;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [127:0] s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	logic [47:0]  m_tdata;
	logic         m_tlast;
	logic         cfg_we;
	logic [2:0]   cfg_index;
	logic [15:0]  cfg_data;

	cftr_pkg::interval_t  throttle_interval [cftr_pkg::NumSlots];
	cftr_pkg::tick_t      last_forward_ms [cftr_pkg::NumSlots];
	cftr_pkg::telemetry_t pending_payloads [$];
	int        mismatch_count = 0;
	bit        idle_on = 1'b1;
	int        stall_left = 0;

	can_frame_throttled_repacker_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#4000000;
		$display("Verification failed");
		$finish;
	end

	function automatic int slot_of(cftr_pkg::can_id_t ident);
		case (ident)
			cftr_pkg::ID_ERPM_VOLTAGE: return int'(cftr_pkg::SLOT_ERPM_VOLTAGE);
			cftr_pkg::ID_TEMPS:        return int'(cftr_pkg::SLOT_TEMPS);
			cftr_pkg::ID_FAN_PUMP:     return int'(cftr_pkg::SLOT_FAN_PUMP);
			cftr_pkg::ID_DRIVE_ENABLE: return int'(cftr_pkg::SLOT_DRIVE_ENABLE);
			cftr_pkg::ID_VCU_ERROR:    return int'(cftr_pkg::SLOT_VCU_ERROR);
			default:                   return -1;
		endcase
	endfunction

	function automatic void queue_payload(logic [7:0] id, logic [2:0] len, logic [7:0] a,
			logic [7:0] b, logic [7:0] c, logic [7:0] d, logic last);
		cftr_pkg::telemetry_t p;
		p.id     = id;
		p.length = len;
		p.byte0  = a;
		p.byte1  = (len > 3'd1) ? b : 8'h00;
		p.byte2  = (len > 3'd2) ? c : 8'h00;
		p.byte3  = (len > 3'd3) ? d : 8'h00;
		p.last   = last;
		pending_payloads.push_back(p);
	endfunction

	function automatic void forward_frame(cftr_pkg::can_id_t ident, logic [63:0] data,
			cftr_pkg::tick_t now);
		int slot;
		cftr_pkg::tick_t elapsed;
		logic [7:0] b [8];
		slot = slot_of(ident);
		if (slot < 0)
			return;
		elapsed = now - last_forward_ms[slot];
		if (elapsed <= cftr_pkg::tick_t'(throttle_interval[slot]))
			return;
		last_forward_ms[slot] = now;
		for (int i = 0; i < 8; i++)
			b[i] = data[8*i +: 8];
		case (cftr_pkg::slot_t'(slot))
			cftr_pkg::SLOT_ERPM_VOLTAGE: begin
				queue_payload(cftr_pkg::PID_ERPM, 3'd4, b[0], b[1], b[2], b[3], 1'b0);
				queue_payload(cftr_pkg::PID_VOLTAGE, 3'd2, b[6], b[7], 8'h00, 8'h00, 1'b1);
			end
			cftr_pkg::SLOT_TEMPS: begin
				queue_payload(cftr_pkg::PID_TEMP_A, 3'd1, b[0], 8'h00, 8'h00, 8'h00, 1'b0);
				queue_payload(cftr_pkg::PID_TEMP_B, 3'd2, b[2], b[3], 8'h00, 8'h00, 1'b0);
				queue_payload(cftr_pkg::PID_TEMP_C, 3'd2, b[0], b[1], 8'h00, 8'h00, 1'b1);
			end
			cftr_pkg::SLOT_FAN_PUMP: begin
				queue_payload(cftr_pkg::PID_FAN, 3'd1, b[0], 8'h00, 8'h00, 8'h00, 1'b0);
				queue_payload(cftr_pkg::PID_PUMP, 3'd1, b[5], 8'h00, 8'h00, 8'h00, 1'b1);
			end
			default: begin
				queue_payload(cftr_pkg::PID_DRIVE_VCU, 3'd1, b[3], 8'h00, 8'h00, 8'h00,
					1'b1);
			end
		endcase
	endfunction

	function automatic logic [63:0] random_bytes();
		return {$urandom, $urandom};
	endfunction

	task automatic send_frame(input cftr_pkg::can_id_t ident, input logic [63:0] data,
			input cftr_pkg::tick_t now);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat ($urandom_range(0, 16)) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= {3'b000, now, data, ident};
		do @(posedge clk); while (s_tready !== 1'b1);
		forward_frame(ident, data, now);
	endtask

	// A dropped frame leaves no trace, so the task keeps idling after the last expected payload.
	task automatic wait_until_idle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_payloads.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_reg(input logic [2:0] index, input logic [15:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		if (index < cftr_pkg::NumSlots)
			throttle_interval[index] = value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	always @(negedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			m_tready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(0, 16);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin : check_payloads
		cftr_pkg::telemetry_t got;
		cftr_pkg::telemetry_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.id     = m_tdata[7:0];
			got.length = m_tdata[10:8];
			got.byte0  = m_tdata[18:11];
			got.byte1  = m_tdata[26:19];
			got.byte2  = m_tdata[34:27];
			got.byte3  = m_tdata[42:35];
			got.last   = m_tlast;
			if (pending_payloads.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected payload: id %h len %0d bytes %h %h %h %h last %0d",
						got.id, got.length, got.byte0, got.byte1, got.byte2, got.byte3,
						got.last);
			end else begin
				want = pending_payloads.pop_front();
				if (got !== want) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display({"payload mismatch: expected id %h len %0d bytes %h %h %h %h ",
							"last %0d, got id %h len %0d bytes %h %h %h %h last %0d"},
							want.id, want.length, want.byte0, want.byte1, want.byte2,
							want.byte3, want.last, got.id, got.length, got.byte0, got.byte1,
							got.byte2, got.byte3, got.last);
				end
			end
		end
	end

	// Interval boundaries at the reset settings, tick wrap and unknown identifiers.
	task automatic test_throttle_edges();
		send_frame(cftr_pkg::ID_ERPM_VOLTAGE, '1, 32'd100);
		send_frame(cftr_pkg::ID_ERPM_VOLTAGE, '1, 32'd101);
		send_frame(cftr_pkg::ID_ERPM_VOLTAGE, '0, 32'd201);
		send_frame(cftr_pkg::ID_ERPM_VOLTAGE, '0, 32'd202);
		send_frame(cftr_pkg::ID_TEMPS, random_bytes(), 32'd101);
		send_frame(cftr_pkg::ID_TEMPS, '1, 32'd150);
		send_frame(cftr_pkg::ID_FAN_PUMP, random_bytes(), 32'd2000);
		send_frame(cftr_pkg::ID_FAN_PUMP, '1, 32'd2001);
		send_frame(cftr_pkg::ID_DRIVE_ENABLE, random_bytes(), 32'hFFFF_FFFF);
		send_frame(cftr_pkg::ID_DRIVE_ENABLE, random_bytes(), 32'h0000_0010);
		send_frame(cftr_pkg::ID_DRIVE_ENABLE, '1, 32'h0000_0070);
		send_frame(cftr_pkg::ID_VCU_ERROR, random_bytes(), 32'd500);
		send_frame(cftr_pkg::ID_VCU_ERROR, random_bytes(), 32'd550);
		send_frame(29'h0000_0000, random_bytes(), $urandom);
		send_frame(29'h1FFF_FFFF, random_bytes(), $urandom);
		send_frame(cftr_pkg::ID_ERPM_VOLTAGE ^ 29'd1, random_bytes(), $urandom);
		send_frame(cftr_pkg::ID_VCU_ERROR | (29'd1 << 28), random_bytes(), $urandom);
		send_frame(cftr_pkg::ID_ERPM_VOLTAGE, random_bytes(), 32'hFFFF_FFFF);
	endtask

	// Writes to indexes beyond the last register must leave every interval alone.
	task automatic test_unused_index();
		wait_until_idle();
		for (int r = REG_FIRST_UNUSED; r <= REG_LAST_UNUSED; r++)
			write_reg(3'(r), 16'h0000);
		send_frame(cftr_pkg::ID_TEMPS, random_bytes(),
			last_forward_ms[cftr_pkg::SLOT_TEMPS] + 32'd100);
		send_frame(cftr_pkg::ID_TEMPS, random_bytes(),
			last_forward_ms[cftr_pkg::SLOT_TEMPS] + 32'd101);
		send_frame(cftr_pkg::ID_VCU_ERROR, random_bytes(),
			last_forward_ms[cftr_pkg::SLOT_VCU_ERROR] + 32'd100);
		send_frame(cftr_pkg::ID_VCU_ERROR, random_bytes(),
			last_forward_ms[cftr_pkg::SLOT_VCU_ERROR] + 32'd101);
	endtask

	task automatic test_interval_extremes();
		wait_until_idle();
		for (int r = REG_ERPM_VOLTAGE; r <= REG_VCU_ERROR; r++)
			write_reg(3'(r), 16'h0000);
		for (int s = 0; s < cftr_pkg::NumSlots; s++) begin
			send_frame(KNOWN_IDS[s], random_bytes(), last_forward_ms[s]);
			send_frame(KNOWN_IDS[s], random_bytes(), last_forward_ms[s] + 32'd1);
		end
		wait_until_idle();
		for (int r = REG_ERPM_VOLTAGE; r <= REG_VCU_ERROR; r++)
			write_reg(3'(r), 16'hFFFF);
		for (int s = 0; s < cftr_pkg::NumSlots; s++) begin
			send_frame(KNOWN_IDS[s], random_bytes(), last_forward_ms[s] + 32'd65535);
			send_frame(KNOWN_IDS[s], random_bytes(), last_forward_ms[s] + 32'd65536);
			send_frame(KNOWN_IDS[s], random_bytes(), last_forward_ms[s]);
		end
	endtask

	// Mostly known frames timed near their interval, with some noise and near-miss identifiers.
	task automatic test_random_traffic();
		int kind;
		int slot;
		cftr_pkg::can_id_t ident;
		cftr_pkg::tick_t now;
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			wait_until_idle();
			if (phase == RANDOM_PHASES - 1)
				idle_on = 1'b0;
			for (int r = REG_ERPM_VOLTAGE; r <= REG_VCU_ERROR; r++) begin
				case ($urandom_range(0, 3))
					0: write_reg(3'(r), 16'h0000);
					1: write_reg(3'(r), 16'hFFFF);
					2: write_reg(3'(r), 16'($urandom_range(0, 300)));
					default: write_reg(3'(r), 16'($urandom));
				endcase
			end
			if (phase == 2)
				write_reg(3'($urandom_range(REG_FIRST_UNUSED, REG_LAST_UNUSED)), 16'($urandom));
			for (int n = 0; n < FRAMES_PER_PHASE; n++) begin
				if (phase == 2 && n == FRAMES_PER_PHASE / 2)
					wait_until_idle();
				kind = $urandom_range(0, 9);
				slot = $urandom_range(0, cftr_pkg::NumSlots - 1);
				if (kind == 0) begin
					ident = 29'($urandom);
					now = $urandom;
				end else if (kind == 1) begin
					ident = KNOWN_IDS[slot] ^ (29'd1 << $urandom_range(0, 28));
					now = $urandom;
				end else if (kind == 2) begin
					ident = KNOWN_IDS[slot];
					now = $urandom;
				end else begin
					ident = KNOWN_IDS[slot];
					now = last_forward_ms[slot] + cftr_pkg::tick_t'(throttle_interval[slot])
						+ 32'($urandom_range(0, 6)) - 32'd3;
				end
				send_frame(ident, random_bytes(), now);
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		for (int s = 0; s < cftr_pkg::NumSlots; s++) begin
			throttle_interval[s] = cftr_pkg::INTERVAL_RESET[s];
			last_forward_ms[s] = '0;
		end
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_throttle_edges();
		test_unused_index();
		test_interval_extremes();
		test_random_traffic();

		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_payloads.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatch_count == 0 && pending_payloads.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// File: can_frame_throttled_repacker_core.f
hdl/cftr_pkg.sv
hdl/can_frame_throttled_repacker_core.sv
tb/sv/testbench.sv
